// ===== rtl/ddg_pkg.sv =====
package ddg_pkg;

    // Iteration count and angle precision
    localparam int CORDIC_ITERATIONS = 16;
    localparam int FRAC_BITS         = 16;

    localparam int POS_W   = 32;
    localparam int QUAT_W  = 16;
    localparam int GAIN_W  = 16;
    localparam int DATA_W  = 32;
    localparam int SHIFT_W = 5;

    // CORDIC vector width and angle widths
    localparam int CW        = 36;
    localparam int ANG_W     = FRAC_BITS + 4;
    localparam int ERR_W     = ANG_W + 1;
    localparam int ANG_SHIFT = 30 - FRAC_BITS;

    localparam logic [31:0] PI_Q30 = 32'd3373259426;
    localparam logic signed [ANG_W-1:0] PI_ANG      = ANG_W'(PI_Q30 >> ANG_SHIFT);
    localparam logic signed [ANG_W-1:0] HALF_PI_ANG = ANG_W'((PI_Q30 >> 1) >> ANG_SHIFT);

    localparam logic signed [33:0] ONE_Q28     = 34'sd268435456;
    localparam logic signed [30:0] INV_GAIN    = 31'sd652032874;
    localparam logic signed [15:0] HALF_BASE   = 16'sd24009;
    localparam logic signed [21:0] INV_RADIUS  = 22'sd1057032;

    localparam logic [31:0] ATAN_Q30 [32] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
        32'h00000001, 32'h00000000
    };

    typedef enum logic [1:0] {
        REG_TARGET_X,
        REG_TARGET_Y,
        REG_GAIN_LINEAR,
        REG_GAIN_ANGULAR
    } reg_index_t;

    typedef struct packed {
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic signed [QUAT_W-1:0] quat_w;
        logic signed [QUAT_W-1:0] quat_x;
        logic signed [QUAT_W-1:0] quat_y;
        logic signed [QUAT_W-1:0] quat_z;
    } pose_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] right_wheel_speed;
        logic signed [DATA_W-1:0] left_wheel_speed;
        logic                     clipped;
    } wheel_t;

    typedef struct packed {
        logic signed [POS_W-1:0] target_x;
        logic signed [POS_W-1:0] target_y;
        logic [GAIN_W-1:0]       gain_linear;
        logic [GAIN_W-1:0]       gain_angular;
    } cfg_t;

    typedef struct packed {
        logic signed [CW-1:0]    x;
        logic signed [CW-1:0]    y;
        logic signed [ANG_W-1:0] z;
        logic                    zero;
    } vec_t;

    typedef struct packed {
        vec_t yaw;
        vec_t goal;
    } cordic_t;

    function automatic logic signed [ANG_W-1:0] atan_ang(input logic [SHIFT_W-1:0] i);
        return ANG_W'(ATAN_Q30[i] >> ANG_SHIFT);
    endfunction

endpackage

// ===== rtl/ddg_prep.sv =====
module ddg_prep (
    input  logic             clk,
    input  logic             rst_n,
    input  ddg_pkg::cfg_t    cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  ddg_pkg::pose_t   in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output ddg_pkg::cordic_t out_data
);
    import ddg_pkg::*;

    logic signed [31:0] wz_reg, xy_reg, yy_reg, zz_reg;
    logic signed [32:0] ex_reg, ey_reg;
    logic               va_reg, vb_reg;
    logic               en_a, en_b;
    logic signed [33:0] siny, cosy;
    cordic_t            out_reg;

    // Start a vector: flag the zero vector, rotate into the right half plane
    function automatic vec_t pre_rotate(input logic signed [CW-1:0] x,
                                        input logic signed [CW-1:0] y);
        vec_t v;
        v.zero = (x == '0) && (y == '0);
        v.x    = x;
        v.y    = y;
        v.z    = '0;
        if (x < 0)
        begin
            if (y >= 0)
            begin
                v.x = y;
                v.y = -x;
                v.z = HALF_PI_ANG;
            end
            else
            begin
                v.x = -y;
                v.y = x;
                v.z = -HALF_PI_ANG;
            end
        end
        return v;
    endfunction

    assign en_b     = !vb_reg || out_ready;
    assign en_a     = !va_reg || en_b;
    assign in_ready = en_a;

    // Form yaw terms from the quaternion
    always_comb
    begin
        siny = (34'(wz_reg) + 34'(xy_reg)) <<< 1;
        cosy = ONE_Q28 - ((34'(yy_reg) + 34'(zz_reg)) <<< 1);
    end

    // Hold stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            if (en_a)
            begin
                va_reg <= in_valid;
            end
            if (en_b)
            begin
                vb_reg <= va_reg;
            end
        end
    end

    // Advance products, position error and first vectors
    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            wz_reg <= in_data.quat_w * in_data.quat_z;
            xy_reg <= in_data.quat_x * in_data.quat_y;
            yy_reg <= in_data.quat_y * in_data.quat_y;
            zz_reg <= in_data.quat_z * in_data.quat_z;
            ex_reg <= 33'(cfg.target_x) - 33'(in_data.pos_x);
            ey_reg <= 33'(cfg.target_y) - 33'(in_data.pos_y);
        end
        if (en_b)
        begin
            out_reg.yaw  <= pre_rotate(CW'(cosy), CW'(siny));
            out_reg.goal <= pre_rotate(CW'(ex_reg), CW'(ey_reg));
        end
    end

    assign out_valid = vb_reg;
    assign out_data  = out_reg;

endmodule

// ===== rtl/ddg_cell.sv =====
module ddg_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [ddg_pkg::SHIFT_W-1:0]   step,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  ddg_pkg::cordic_t              in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output ddg_pkg::cordic_t              out_data
);
    import ddg_pkg::*;

    logic    valid_reg;
    cordic_t data_reg;
    cordic_t data_next;

    // One vectoring micro-rotation: drive y toward zero
    function automatic vec_t rotate(input vec_t v, input logic [SHIFT_W-1:0] s);
        vec_t                    r;
        logic signed [CW-1:0]    dx;
        logic signed [CW-1:0]    dy;
        logic signed [ANG_W-1:0] a;
        dx = v.y >>> s;
        dy = v.x >>> s;
        a  = atan_ang(s);
        r  = v;
        if (v.y > 0)
        begin
            r.x = v.x + dx;
            r.y = v.y - dy;
            r.z = v.z + a;
        end
        else
        begin
            r.x = v.x - dx;
            r.y = v.y + dy;
            r.z = v.z - a;
        end
        return r;
    endfunction

    always_comb
    begin
        data_next.yaw  = rotate(in_data.yaw, step);
        data_next.goal = rotate(in_data.goal, step);
    end

    assign in_ready = !valid_reg || out_ready;

    // Hold valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Advance vectors
    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== rtl/ddg_post.sv =====
module ddg_post (
    input  logic             clk,
    input  logic             rst_n,
    input  ddg_pkg::cfg_t    cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  ddg_pkg::cordic_t in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output ddg_pkg::wheel_t  out_data
);
    import ddg_pkg::*;

    localparam int MAG_SPLIT = 18;
    localparam int HI_W      = CW - MAG_SPLIT;
    localparam int PROD_W    = HI_W + 31;
    localparam int SUM_W     = PROD_W + MAG_SPLIT;
    localparam int DIST_W    = 35;
    localparam int WP_W      = ERR_W + GAIN_W + 1;
    localparam int W_W       = 30;
    localparam int VP_W      = DIST_W + GAIN_W + 1;
    localparam int V_W       = VP_W - 8;
    localparam int TP_W      = W_W + 16;
    localparam int TURN_W    = TP_W - 16;
    localparam int S_W       = V_W + 1;
    localparam int CL_W      = 29;
    localparam int RP_W      = CL_W + 22;
    localparam int Q_W       = RP_W - 16;

    localparam logic signed [S_W-1:0] S_LIM  = S_W'(64'sd134217728);
    localparam logic signed [Q_W-1:0] Q_MAX  = Q_W'(64'sd2147483647);
    localparam logic signed [Q_W-1:0] Q_MIN  = Q_W'(-64'sd2147483648);
    localparam logic signed [ERR_W-1:0] E_PI = ERR_W'(PI_ANG);

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic en1, en2, en3, en4, en5, en6;

    logic signed [ERR_W-1:0]  err_reg;
    logic signed [PROD_W-1:0] ph_reg, pl_reg;
    logic signed [DIST_W-1:0] dist_reg;
    logic signed [W_W-1:0]    w_reg;
    logic signed [V_W-1:0]    v_reg;
    logic signed [TURN_W-1:0] turn_reg;
    logic signed [CL_W-1:0]   sr_reg, sl_reg;
    logic signed [RP_W-1:0]   pr_reg, pl2_reg;
    wheel_t                   out_reg;

    logic signed [ANG_W-1:0]  theta, bearing;
    logic signed [ERR_W-1:0]  diff, err_next;
    logic signed [CW-1:0]     mag;
    logic signed [PROD_W-1:0] ph_next, pl_next;
    logic signed [SUM_W-1:0]  dsum;
    logic signed [WP_W-1:0]   wp;
    logic signed [VP_W-1:0]   vp;
    logic signed [TP_W-1:0]   tp;
    logic signed [S_W-1:0]    sr, sl;
    logic signed [Q_W-1:0]    qr, ql;
    wheel_t                   out_next;

    function automatic logic signed [CL_W-1:0] clamp(input logic signed [S_W-1:0] s);
        if (s > S_LIM)
        begin
            return CL_W'(S_LIM);
        end
        else if (s < -S_LIM)
        begin
            return CL_W'(-S_LIM);
        end
        return CL_W'(s);
    endfunction

    assign en6      = !v6_reg || !out_stall;
    assign en5      = !v5_reg || en6;
    assign en4      = !v4_reg || en5;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    // Heading error with wrap, split magnitude products
    always_comb
    begin
        theta   = in_data.yaw.zero  ? '0 : in_data.yaw.z;
        bearing = in_data.goal.zero ? '0 : in_data.goal.z;
        diff    = ERR_W'(bearing) - ERR_W'(theta);
        if (diff > E_PI)
        begin
            err_next = diff - (E_PI <<< 1);
        end
        else if (diff < -E_PI)
        begin
            err_next = diff + (E_PI <<< 1);
        end
        else
        begin
            err_next = diff;
        end
        mag     = in_data.goal.zero ? '0 : in_data.goal.x;
        ph_next = $signed(mag[CW-1:MAG_SPLIT]) * INV_GAIN;
        pl_next = $signed({1'b0, mag[MAG_SPLIT-1:0]}) * INV_GAIN;
    end

    // Distance, gain products, turn rate, wheel sums and radius scaling
    always_comb
    begin
        dsum = (SUM_W'(ph_reg) <<< MAG_SPLIT) + SUM_W'(pl_reg);
        wp   = $signed({1'b0, cfg.gain_angular}) * err_reg;
        vp   = $signed({1'b0, cfg.gain_linear}) * dist_reg;
        tp   = w_reg * HALF_BASE;
        sr   = S_W'(v_reg) + S_W'(turn_reg);
        sl   = S_W'(v_reg) - S_W'(turn_reg);
        qr   = Q_W'(pr_reg >>> 16);
        ql   = Q_W'(pl2_reg >>> 16);
    end

    // Saturate wheel speeds
    always_comb
    begin
        out_next.clipped = 1'b0;
        if (qr > Q_MAX)
        begin
            out_next.right_wheel_speed = DATA_W'(Q_MAX);
            out_next.clipped           = 1'b1;
        end
        else if (qr < Q_MIN)
        begin
            out_next.right_wheel_speed = DATA_W'(Q_MIN);
            out_next.clipped           = 1'b1;
        end
        else
        begin
            out_next.right_wheel_speed = DATA_W'(qr);
        end
        if (ql > Q_MAX)
        begin
            out_next.left_wheel_speed = DATA_W'(Q_MAX);
            out_next.clipped          = 1'b1;
        end
        else if (ql < Q_MIN)
        begin
            out_next.left_wheel_speed = DATA_W'(Q_MIN);
            out_next.clipped          = 1'b1;
        end
        else
        begin
            out_next.left_wheel_speed = DATA_W'(ql);
        end
    end

    // Hold stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
            if (en6) v6_reg <= v5_reg;
        end
    end

    // Advance datapath stages
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            err_reg <= err_next;
            ph_reg  <= ph_next;
            pl_reg  <= pl_next;
        end
        if (en2)
        begin
            dist_reg <= DIST_W'(dsum >>> 30);
            w_reg    <= W_W'(wp >>> (FRAC_BITS - 8));
        end
        if (en3)
        begin
            v_reg    <= V_W'(vp >>> 8);
            turn_reg <= TURN_W'(tp >>> 16);
        end
        if (en4)
        begin
            sr_reg <= clamp(sr);
            sl_reg <= clamp(sl);
        end
        if (en5)
        begin
            pr_reg  <= sr_reg * INV_RADIUS;
            pl2_reg <= sl_reg * INV_RADIUS;
        end
        if (en6)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = v6_reg;
    assign out_data  = out_reg;

endmodule

// ===== rtl/diff_drive_go_to_goal.sv =====
// Go-to-goal controller for a differential-drive base.
// Pose channel: pose_valid / pose_stall carry one odometry item (position
// Q16.16, quaternion Q1.14). Wheel channel: wheel_valid / wheel_stall carry
// right and left wheel speeds (Q16.16 rad/s, saturated) and a clip flag.
// Configuration: wr_en, wr_index, wr_data write target and gains; write only
// while the block is idle.
// The pipeline has two input stages, one CORDIC cell per iteration for yaw
// and bearing in parallel, and six output stages for distance, gains, wheel
// mix and saturation.
// Throughput is one item per cycle while wheel_stall is low; every stage holds its own valid bit.
// When wheel_stall is high the finished item holds, and upstream stages
// keep filling empty slots; pose_stall rises only once the chain is full.
// Reset clears all valid bits and sets target and gains to zero.
module diff_drive_go_to_goal (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        pose_valid,
    output logic                        pose_stall,
    input  ddg_pkg::pose_t              pose,
    output logic                        wheel_valid,
    input  logic                        wheel_stall,
    output ddg_pkg::wheel_t             wheel,
    input  logic                        wr_en,
    input  ddg_pkg::reg_index_t         wr_index,
    input  logic [ddg_pkg::DATA_W-1:0]  wr_data
);
    import ddg_pkg::*;

    cfg_t    cfg_reg;
    logic    prep_ready;
    logic    chain_valid [CORDIC_ITERATIONS+1];
    logic    chain_ready [CORDIC_ITERATIONS+1];
    cordic_t chain_data  [CORDIC_ITERATIONS+1];

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_TARGET_X:     cfg_reg.target_x     <= wr_data;
                REG_TARGET_Y:     cfg_reg.target_y     <= wr_data;
                REG_GAIN_LINEAR:  cfg_reg.gain_linear  <= wr_data[GAIN_W-1:0];
                REG_GAIN_ANGULAR: cfg_reg.gain_angular <= wr_data[GAIN_W-1:0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    assign pose_stall = !prep_ready;

    ddg_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (pose_valid),
        .in_ready  (prep_ready),
        .in_data   (pose),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_data  (chain_data[0])
    );

    // One cell per CORDIC iteration
    for (genvar k = 0; k < CORDIC_ITERATIONS; k++)
    begin : g_cell
        ddg_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .step      (SHIFT_W'(k)),
            .in_valid  (chain_valid[k]),
            .in_ready  (chain_ready[k]),
            .in_data   (chain_data[k]),
            .out_valid (chain_valid[k+1]),
            .out_ready (chain_ready[k+1]),
            .out_data  (chain_data[k+1])
        );
    end

    ddg_post u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (chain_valid[CORDIC_ITERATIONS]),
        .in_ready  (chain_ready[CORDIC_ITERATIONS]),
        .in_data   (chain_data[CORDIC_ITERATIONS]),
        .out_valid (wheel_valid),
        .out_stall (wheel_stall),
        .out_data  (wheel)
    );

endmodule

// ===== verif/ddg_checker.sv =====
`timescale 1ns / 1ps

module ddg_checker
    import ddg_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pose_valid,
    input  logic                pose_stall,
    input  pose_t               pose,
    input  logic                wheel_valid,
    input  logic                wheel_stall,
    input  wheel_t              wheel,
    input  logic                wr_en,
    input  reg_index_t          wr_index,
    input  logic [DATA_W-1:0]   wr_data,
    output int                  fail_count,
    output int                  pending
);

    localparam longint ANG_PI   = longint'(PI_Q30 >> (30 - FRAC_BITS));
    localparam longint ANG_HALF = longint'((PI_Q30 / 2) >> (30 - FRAC_BITS));

    logic signed [31:0] goal_x, goal_y;
    logic [15:0]        k_lin, k_ang;
    wheel_t             wheel_q[$];

    function automatic longint angle_of(input longint x0, input longint y0,
                                        output longint mag);
        longint x, y, z, dx, dy, t;
        x = x0;
        y = y0;
        z = 0;
        if (x == 0 && y == 0)
        begin
            mag = 0;
            return 0;
        end
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y; y = -t; z = ANG_HALF;
            end
            else
            begin
                x = -y; y = t; z = -ANG_HALF;
            end
        end
        for (int i = 0; i < CORDIC_ITERATIONS; i++)
        begin
            dx = y >>> (i & 31);
            dy = x >>> (i & 31);
            if (y > 0)
            begin
                x += dx; y -= dy; z += longint'(ATAN_Q30[i & 31] >> (30 - FRAC_BITS));
            end
            else
            begin
                x -= dx; y += dy; z -= longint'(ATAN_Q30[i & 31] >> (30 - FRAC_BITS));
            end
        end
        mag = x;
        return z;
    endfunction

    function automatic longint clamp32(input longint v, inout bit clip);
        if (v > 64'sd2147483647)
        begin
            clip = 1; return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            clip = 1; return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic wheel_t wheel_speeds(input pose_t p);
        longint qw, qx, qy, qz, sy, cy, m, yaw, brg, err, distance, v, w, turn;
        bit clip;
        wheel_t r;
        qw = p.quat_w; qx = p.quat_x; qy = p.quat_y; qz = p.quat_z;
        clip = 0;
        sy = 2 * (qw * qz + qx * qy);
        cy = 64'sd268435456 - 2 * (qy * qy + qz * qz);
        yaw = angle_of(cy, sy, m);
        brg = angle_of(longint'(goal_x) - longint'(p.pos_x),
                       longint'(goal_y) - longint'(p.pos_y), m);
        distance = (m * 64'sd652032874) >>> 30;
        err = brg - yaw;
        if (err > ANG_PI)
            err -= 2 * ANG_PI;
        else if (err < -ANG_PI)
            err += 2 * ANG_PI;
        v = (longint'(k_lin) * distance) >>> 8;
        w = (longint'(k_ang) * err) >>> (FRAC_BITS - 8);
        turn = (w * 24009) >>> 16;
        r.right_wheel_speed = 32'(clamp32(((v + turn) * 1057032) >>> 16, clip));
        r.left_wheel_speed  = 32'(clamp32(((v - turn) * 1057032) >>> 16, clip));
        r.clipped = clip;
        return r;
    endfunction

    assign pending = wheel_q.size();

    // track registers, predict on pose accept, compare on wheel accept
    always @(posedge clk or negedge rst_n)
    begin
        wheel_t exp_w;
        if (!rst_n)
        begin
            goal_x = 0; goal_y = 0; k_lin = 0; k_ang = 0;
            fail_count = 0;
            wheel_q.delete();
        end
        else
        begin
            if (wheel_valid && !wheel_stall)
            begin
                if (wheel_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected wheel item %h", wheel);
                end
                else
                begin
                    exp_w = wheel_q.pop_front();
                    if (wheel !== exp_w)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch exp r=%0d l=%0d c=%b got r=%0d l=%0d c=%b",
                                     exp_w.right_wheel_speed, exp_w.left_wheel_speed,
                                     exp_w.clipped, wheel.right_wheel_speed,
                                     wheel.left_wheel_speed, wheel.clipped);
                    end
                end
            end
            if (pose_valid && !pose_stall)
                wheel_q.push_back(wheel_speeds(pose));
            if (wr_en)
            begin
                case (wr_index)
                    REG_TARGET_X:     goal_x = wr_data;
                    REG_TARGET_Y:     goal_y = wr_data;
                    REG_GAIN_LINEAR:  k_lin = wr_data[15:0];
                    REG_GAIN_ANGULAR: k_ang = wr_data[15:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import ddg_pkg::*;

    logic               clk = 0;
    logic               rst_n = 0;
    logic               pose_valid = 0;
    logic               pose_stall;
    pose_t              pose = '0;
    logic               wheel_valid;
    logic               wheel_stall = 1;
    wheel_t             wheel;
    logic               wr_en = 0;
    reg_index_t         wr_index = REG_TARGET_X;
    logic [DATA_W-1:0]  wr_data = '0;
    int                 fail_count;
    int                 pending;
    int                 cycle_count = 0;

    diff_drive_go_to_goal dut (.*);
    ddg_checker chk (.*);

    always #6 clk = ~clk;

    // cycle limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > 400000)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver stalls: hold for a random gap, then take one item
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
            @(negedge clk);
            if (gap != 0)
            begin
                wheel_stall <= 1;
                repeat (gap) @(negedge clk);
            end
            wheel_stall <= 0;
            do @(posedge clk); while (!wheel_valid);
        end
    end

    task automatic write_reg(input reg_index_t idx, input logic [31:0] val);
        @(negedge clk);
        wr_en <= 1; wr_index <= idx; wr_data <= val;
        @(negedge clk);
        wr_en <= 0;
    endtask

    task automatic drain;
        while (pending != 0) @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic send_pose(input pose_t p, input bit fast);
        int gap;
        gap = fast ? 0 : $urandom_range(0, 10);
        @(negedge clk);
        if (gap != 0)
        begin
            pose_valid <= 0;
            repeat (gap - 1) @(negedge clk);
            @(negedge clk);
        end
        pose_valid <= 1;
        pose <= p;
        do @(posedge clk); while (pose_stall);
    endtask

    function automatic logic signed [15:0] rand_quat();
        case ($urandom_range(0, 5))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'($urandom);
            default: return 16'($urandom_range(0, 32768) - 16384);
        endcase
    endfunction

    function automatic logic signed [31:0] rand_pos();
        case ($urandom_range(0, 4))
            0: return 32'($urandom);
            1: return 32'sh7FFFFFFF;
            2: return 32'sh80000000;
            default: return 32'($urandom_range(0, 32'h00140000)) - 32'sh000A0000;
        endcase
    endfunction

    initial
    begin
        pose_t p;
        bit fast;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;

        // directed: at target, zero quaternion, extremes
        write_reg(REG_GAIN_LINEAR, 32'h0100);
        write_reg(REG_GAIN_ANGULAR, 32'h0200);
        send_pose('0, 0);
        send_pose('{32'sh00010000, 32'sh00020000, 16'sd16384, 0, 0, 0}, 0);
        send_pose('{-32'sh00030000, 32'sh00010000, 0, 0, 0, 16'sd16384}, 0);
        send_pose('{32'sh7FFFFFFF, 32'sh80000000, -16'sd16384, 16'sd16384,
                    16'sd16384, -16'sd16384}, 0);
        send_pose('{32'sh80000000, 32'sh7FFFFFFF, 16'sh7FFF, 16'sh8000,
                    16'sh7FFF, 16'sh8000}, 0);
        send_pose('{32'sh00050000, 0, 0, 0, 0, -16'sd16384}, 0);
        send_pose('{0, -32'sh00050000, 16'sd11585, 0, 0, -16'sd11585}, 1);
        send_pose('{-32'sh00050000, -32'sh00000001, 0, 16'sd16384, 0, 0}, 1);
        pose_valid <= 0;
        drain();
        write_reg(REG_TARGET_X, 32'h7FFFFFFF);
        write_reg(REG_TARGET_Y, 32'h80000000);
        write_reg(REG_GAIN_LINEAR, 32'hFFFF);
        write_reg(REG_GAIN_ANGULAR, 32'hFFFF);
        send_pose('{32'sh80000000, 32'sh7FFFFFFF, 0, 0, 0, 16'sd16384}, 0);
        send_pose('{32'sh7FFFFFFF, 32'sh80000000, 16'sd16384, 0, 0, 0}, 0);
        send_pose('0, 1);
        pose_valid <= 0;
        drain();

        // random phases with new targets and gains
        for (int ph = 0; ph < 8; ph++)
        begin
            write_reg(REG_TARGET_X, (ph == 7) ? 32'h80000000 : $urandom_range(0, 32'h00140000) - 32'h000A0000);
            write_reg(REG_TARGET_Y, (ph == 6) ? 32'h7FFFFFFF : $urandom_range(0, 32'h00140000) - 32'h000A0000);
            write_reg(REG_GAIN_LINEAR, (ph == 0) ? 32'h0 : (ph == 1) ? 32'hFFFF : $urandom_range(0, 32'h0400));
            write_reg(REG_GAIN_ANGULAR, (ph == 0) ? 32'hFFFF : (ph == 1) ? 32'h0 : $urandom_range(0, 32'h0400));
            for (int n = 0; n < 125; n++)
            begin
                p.pos_x = rand_pos();
                p.pos_y = rand_pos();
                p.quat_w = rand_quat();
                p.quat_x = rand_quat();
                p.quat_y = rand_quat();
                p.quat_z = rand_quat();
                fast = (n % 40) < 12;
                send_pose(p, fast);
            end
            pose_valid <= 0;
            drain();
        end

        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/ddg_pkg.sv
rtl/ddg_prep.sv
rtl/ddg_cell.sv
rtl/ddg_post.sv
rtl/diff_drive_go_to_goal.sv
verif/ddg_checker.sv
verif/tb.sv
